// ===== sv/qchm_pkg.sv =====
// ----------------------------------------------------------------------------
// qchm_pkg: shared constants, types and helpers
// Bin geometry, counter width and the controller/datapath command bundle for
// the quantized color histogram mode block.
// ----------------------------------------------------------------------------
`default_nettype none

package qchm_pkg;

   localparam int COUNT_BITS  = 22;
   localparam int LEVEL_SHIFT = 4;
   localparam int CHAN_BITS   = 8 - LEVEL_SHIFT;
   localparam int BIN_BITS    = 3 * CHAN_BITS;
   localparam int BIN_TOTAL   = 1 << BIN_BITS;

   localparam logic [COUNT_BITS-1:0]  COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [LEVEL_SHIFT-1:0] HALF_STEP = LEVEL_SHIFT'(1) << (LEVEL_SHIFT - 1);

   typedef struct packed {
      logic pix_rd;    // read the bin of the incoming pixel
      logic pix_wr;    // write back the incremented count
      logic scan;      // read and clear the entry at the sweep address
      logic clr;       // write zero at the sweep address
      logic addr_inc;  // advance the sweep address
      logic best_clr;  // restart the maximum search
      logic load_out;  // load the result register
   } qchm_cmd_type;

   typedef struct packed {
      logic addr_last;  // sweep address is at the final bin
      logic last_pixel; // pixel in flight closes the image
   } qchm_sts_type;

   function automatic logic [BIN_BITS-1:0] bin_of(input logic [7:0] r,
                                                  input logic [7:0] g,
                                                  input logic [7:0] b);
      bin_of = {r[7 -: CHAN_BITS], g[7 -: CHAN_BITS], b[7 -: CHAN_BITS]};
   endfunction

   function automatic logic [7:0] centre_of(input logic [CHAN_BITS-1:0] part);
      centre_of = {part, HALF_STEP};
   endfunction

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] cnt);
      sat_inc = (cnt == COUNT_MAX) ? cnt : cnt + COUNT_BITS'(1);
   endfunction

endpackage

`default_nettype wire

// ===== sv/qchm_dpath.sv =====
// ----------------------------------------------------------------------------
// qchm_dpath: histogram memory and search datapath
// Holds the bin counters, performs read-modify-write per pixel, sweeps the
// memory for the maximum while clearing it, and keeps the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module qchm_dpath
   import qchm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire qchm_cmd_type          cmd,
   output qchm_sts_type               sts,
   input  wire logic [7:0]            req_red,
   input  wire logic [7:0]            req_green,
   input  wire logic [7:0]            req_blue,
   input  wire logic                  req_last_pixel,
   output logic [7:0]                 rsp_dominant_red,
   output logic [7:0]                 rsp_dominant_green,
   output logic [7:0]                 rsp_dominant_blue,
   output logic [COUNT_BITS-1:0]      rsp_winning_count
);

   logic [COUNT_BITS-1:0] mem [BIN_TOTAL];

   logic [BIN_BITS-1:0]   addr_ff, addr_in;
   logic [BIN_BITS-1:0]   addr_dly_ff;
   logic                  cmp_pend_ff;
   logic [BIN_BITS-1:0]   bin_ff;
   logic                  last_ff;
   logic [COUNT_BITS-1:0] rdata_ff;
   logic [BIN_BITS-1:0]   best_bin_ff, best_bin_in;
   logic [COUNT_BITS-1:0] best_count_ff, best_count_in;
   logic [7:0]            red_ff, green_ff, blue_ff;
   logic [COUNT_BITS-1:0] count_ff;

   logic                  mem_re, mem_we;
   logic [BIN_BITS-1:0]   raddr, waddr;
   logic [COUNT_BITS-1:0] wdata;

   assign mem_re = cmd.pix_rd | cmd.scan;
   assign mem_we = cmd.pix_wr | cmd.scan | cmd.clr;
   assign raddr  = cmd.pix_rd ? bin_of(req_red, req_green, req_blue) : addr_ff;
   assign waddr  = cmd.pix_wr ? bin_ff : addr_ff;
   assign wdata  = cmd.pix_wr ? sat_inc(rdata_ff) : '0;

   // read returns the old entry when the same address is cleared in the sweep
   always_ff @(posedge clock) begin
      if (mem_re) begin
         rdata_ff <= mem[raddr];
      end
      if (mem_we) begin
         mem[waddr] <= wdata;
      end
   end

   assign addr_in = cmd.addr_inc ? addr_ff + BIN_BITS'(1) : addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff     <= '0;
         cmp_pend_ff <= 1'b0;
      end else begin
         addr_ff     <= addr_in;
         cmp_pend_ff <= cmd.scan;
      end
   end

   always_comb begin
      best_bin_in   = best_bin_ff;
      best_count_in = best_count_ff;
      priority if (cmd.best_clr) begin
         best_bin_in   = '0;
         best_count_in = '0;
      end else if (cmp_pend_ff && (rdata_ff > best_count_ff)) begin
         // strict compare keeps the lowest bin on ties
         best_bin_in   = addr_dly_ff;
         best_count_in = rdata_ff;
      end else begin
         best_bin_in   = best_bin_ff;
         best_count_in = best_count_ff;
      end
   end

   always_ff @(posedge clock) begin
      addr_dly_ff   <= addr_ff;
      best_bin_ff   <= best_bin_in;
      best_count_ff <= best_count_in;
      if (cmd.pix_rd) begin
         bin_ff  <= bin_of(req_red, req_green, req_blue);
         last_ff <= req_last_pixel;
      end
      if (cmd.load_out) begin
         red_ff   <= centre_of(best_bin_ff[BIN_BITS-1 -: CHAN_BITS]);
         green_ff <= centre_of(best_bin_ff[2*CHAN_BITS-1 -: CHAN_BITS]);
         blue_ff  <= centre_of(best_bin_ff[CHAN_BITS-1:0]);
         count_ff <= best_count_ff;
      end
   end

   assign sts.addr_last  = (addr_ff == {BIN_BITS{1'b1}});
   assign sts.last_pixel = last_ff;

   assign rsp_dominant_red   = red_ff;
   assign rsp_dominant_green = green_ff;
   assign rsp_dominant_blue  = blue_ff;
   assign rsp_winning_count  = count_ff;

endmodule

`default_nettype wire

// ===== sv/qchm_ctrl.sv =====
// ----------------------------------------------------------------------------
// qchm_ctrl: sequencing state machine
// Runs the post-reset clearing sweep, the per-pixel read-modify-write, the
// end-of-image search sweep and the result handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module qchm_ctrl
   import qchm_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output qchm_cmd_type      cmd,
   input  wire qchm_sts_type sts
);

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_UPDATE = 6'b000100,
      ST_SCAN   = 6'b001000,
      ST_DRAIN  = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr      = 1'b1;
            cmd.addr_inc = 1'b1;
            if (sts.addr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.pix_rd = 1'b1;
               state_in   = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.pix_wr = 1'b1;
            if (sts.last_pixel) begin
               cmd.best_clr = 1'b1;
               state_in     = ST_SCAN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            cmd.scan     = 1'b1;
            cmd.addr_inc = 1'b1;
            if (sts.addr_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // let the final compare land
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load_out | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_accept_update: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_UPDATE))
      else $error("accepted transaction did not enter update");

   a_scan_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && sts.addr_last) |=> (state_ff == ST_DRAIN))
      else $error("sweep did not stop at the final bin");

   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid_ff)
      else $error("result load did not raise valid");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !cmd.load_out)
      else $error("stalled result overwritten");

endmodule

`default_nettype wire

// ===== sv/quantized_color_histogram_mode_top.sv =====
// Flow: each pixel is a single read-modify-write on the histogram memory
// (memory read, then write back), and req_stall holds off the next pixel
// until the write back is done; the last pixel of an image also starts the
// 4096-entry search sweep, which runs once per image and ends in the result load.
// Reset: a clearing sweep of the histogram follows reset, with
// req_stall high until it ends.
// ----------------------------------------------------------------------------
// quantized_color_histogram_mode_top: dominant color by 4-bit RGB histogram
// Counts pixels into 4096 saturating bins and reports the fullest bin's
// centre and count on the last pixel of each image.
// ----------------------------------------------------------------------------
`default_nettype none

module quantized_color_histogram_mode_top
   import qchm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [7:0]            req_red,
   input  wire logic [7:0]            req_green,
   input  wire logic [7:0]            req_blue,
   input  wire logic                  req_last_pixel,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [7:0]                 rsp_dominant_red,
   output logic [7:0]                 rsp_dominant_green,
   output logic [7:0]                 rsp_dominant_blue,
   output logic [COUNT_BITS-1:0]      rsp_winning_count
);

   qchm_cmd_type cmd;
   qchm_sts_type sts;

   qchm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   qchm_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_red            (req_red),
      .req_green          (req_green),
      .req_blue           (req_blue),
      .req_last_pixel     (req_last_pixel),
      .rsp_dominant_red   (rsp_dominant_red),
      .rsp_dominant_green (rsp_dominant_green),
      .rsp_dominant_blue  (rsp_dominant_blue),
      .rsp_winning_count  (rsp_winning_count)
   );

endmodule

`default_nettype wire

// ===== tb/tb_quantized_color_histogram_mode_top.sv =====
// ----------------------------------------------------------------------------
// tb_quantized_color_histogram_mode_top: dominant color histogram testbench
// Streams images of RGB pixels through the block and checks every reported
// dominant bin centre and count against a cycle-free histogram model kept
// here. Covers extreme bins, ties, low-nibble aliasing, random images and
// random input gaps and output stalls, including one long output hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_quantized_color_histogram_mode_top;
   import qchm_pkg::*;

   localparam int ITEM_TARGET    = 1450;
   localparam int HOLD_CYCLES    = 10000;
   localparam int WATCHDOG_LIMIT = 40000;
   localparam int DRAIN_CYCLES   = 4500;
   localparam int REPORT_LIMIT   = 10;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last_pixel;
   } pixel_type;

   typedef struct packed {
      logic [7:0]            red;
      logic [7:0]            green;
      logic [7:0]            blue;
      logic [COUNT_BITS-1:0] count;
   } dominant_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [7:0]            req_red = 8'd0;
   logic [7:0]            req_green = 8'd0;
   logic [7:0]            req_blue = 8'd0;
   logic                  req_last_pixel = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [7:0]            rsp_dominant_red;
   logic [7:0]            rsp_dominant_green;
   logic [7:0]            rsp_dominant_blue;
   logic [COUNT_BITS-1:0] rsp_winning_count;

   quantized_color_histogram_mode_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_red            (req_red),
      .req_green          (req_green),
      .req_blue           (req_blue),
      .req_last_pixel     (req_last_pixel),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_dominant_red   (rsp_dominant_red),
      .rsp_dominant_green (rsp_dominant_green),
      .rsp_dominant_blue  (rsp_dominant_blue),
      .rsp_winning_count  (rsp_winning_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   pixel_type             pixel_queue[$];
   dominant_type          dominant_queue[$];
   logic [COUNT_BITS-1:0] bin_tally [BIN_TOTAL];

   int items_queued   = 0;
   int images_queued  = 0;
   int pixels_sent    = 0;
   int results_seen   = 0;
   int errors         = 0;
   int burst_left     = 0;
   int gap_left       = 0;
   int hold_left      = 0;
   bit hold_done      = 1'b0;
   int stall_pct      = 0;
   int pattern_left   = 0;
   int idle_cycles    = 0;

   function automatic logic [7:0] bin_centre(input logic [CHAN_BITS-1:0] part);
      return (8'(part) << LEVEL_SHIFT) + 8'(1 << (LEVEL_SHIFT - 1));
   endfunction

   // Count one pixel; on the closing pixel search the fullest bin and restart.
   task automatic tally_pixel(input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b, input logic last_pixel);
      logic [BIN_BITS-1:0]   bin;
      logic [BIN_BITS-1:0]   best;
      logic [COUNT_BITS-1:0] top;
      dominant_type          d;
      bin = {CHAN_BITS'(r >> LEVEL_SHIFT), CHAN_BITS'(g >> LEVEL_SHIFT),
             CHAN_BITS'(b >> LEVEL_SHIFT)};
      if (bin_tally[bin] != COUNT_MAX)
         bin_tally[bin] = bin_tally[bin] + COUNT_BITS'(1);
      if (last_pixel) begin
         best = '0;
         top  = '0;
         // strict compare keeps the lowest bin on a tie
         for (int i = 0; i < BIN_TOTAL; i++) begin
            if (bin_tally[i] > top) begin
               top  = bin_tally[i];
               best = BIN_BITS'(i);
            end
         end
         d.red   = bin_centre(best[BIN_BITS-1 -: CHAN_BITS]);
         d.green = bin_centre(best[CHAN_BITS +: CHAN_BITS]);
         d.blue  = bin_centre(best[CHAN_BITS-1:0]);
         d.count = top;
         dominant_queue.push_back(d);
         for (int i = 0; i < BIN_TOTAL; i++)
            bin_tally[i] = '0;
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         errors++;
         if (errors <= REPORT_LIMIT)
            $display("mismatch on %s in result %0d: expected %0d, got %0d",
                     name, results_seen, want, got);
      end
   endtask

   task automatic add_pixel(input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b, input logic last_pixel);
      pixel_type p;
      p.red        = r;
      p.green      = g;
      p.blue       = b;
      p.last_pixel = last_pixel;
      pixel_queue.push_back(p);
      items_queued++;
      if (last_pixel)
         images_queued++;
   endtask

   function automatic pixel_type random_pixel();
      pixel_type p;
      p.red        = 8'($urandom_range(0, 255));
      p.green      = 8'($urandom_range(0, 255));
      p.blue       = 8'($urandom_range(0, 255));
      p.last_pixel = 1'b0;
      return p;
   endfunction

   // Driver: bursts of transactions separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            tally_pixel(req_red, req_green, req_blue, req_last_pixel);
            pixels_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pixel_queue.size() > 0) begin
               req_valid      <= 1'b1;
               req_red        <= pixel_queue[0].red;
               req_green      <= pixel_queue[0].green;
               req_blue       <= pixel_queue[0].blue;
               req_last_pixel <= pixel_queue[0].last_pixel;
               void'(pixel_queue.pop_front());
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver stall: changing duty cycles, plus one long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!hold_done && results_seen >= 6) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         if (pattern_left == 0) begin
            case ($urandom_range(0, 2))
               0: stall_pct = 0;
               1: stall_pct = 20;
               default: stall_pct = 60;
            endcase
            pattern_left = $urandom_range(50, 400);
         end else begin
            pattern_left--;
         end
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // Monitor: compare each result transaction with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (dominant_queue.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("unexpected result: red %0d green %0d blue %0d count %0d",
                        rsp_dominant_red, rsp_dominant_green, rsp_dominant_blue,
                        rsp_winning_count);
         end else begin
            check_field("dominant_red", 32'(rsp_dominant_red),
                        32'(dominant_queue[0].red));
            check_field("dominant_green", 32'(rsp_dominant_green),
                        32'(dominant_queue[0].green));
            check_field("dominant_blue", 32'(rsp_dominant_blue),
                        32'(dominant_queue[0].blue));
            check_field("winning_count", 32'(rsp_winning_count),
                        32'(dominant_queue[0].count));
            void'(dominant_queue.pop_front());
         end
         results_seen++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      pixel_type palette [4];
      pixel_type p;
      int        kind;
      int        len;
      int        reps;
      int        colors;
      foreach (bin_tally[i])
         bin_tally[i] = '0;

      // single-pixel images at both corners of the color cube
      add_pixel(8'h00, 8'h00, 8'h00, 1'b1);
      add_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
      // tie between the top and bottom bins: bottom wins
      add_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
      add_pixel(8'h00, 8'h00, 8'h00, 1'b1);
      // low nibbles must not split a bin
      add_pixel(8'h0F, 8'h0F, 8'h0F, 1'b0);
      add_pixel(8'h00, 8'h00, 8'h00, 1'b0);
      add_pixel(8'h80, 8'h40, 8'h20, 1'b1);
      // one channel at a time
      add_pixel(8'hF0, 8'h00, 8'h00, 1'b0);
      add_pixel(8'hF7, 8'h0A, 8'h05, 1'b0);
      add_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
      add_pixel(8'h00, 8'h00, 8'hFF, 1'b1);
      // alternating bit patterns tie at two counts: lower bin wins
      add_pixel(8'hAA, 8'h55, 8'hC3, 1'b0);
      add_pixel(8'h3C, 8'h5A, 8'hA5, 1'b0);
      add_pixel(8'h3C, 8'h5A, 8'hA5, 1'b0);
      add_pixel(8'hAA, 8'h55, 8'hC3, 1'b1);

      while (items_queued < ITEM_TARGET) begin
         kind = $urandom_range(0, 9);
         for (int c = 0; c < 4; c++)
            palette[c] = random_pixel();
         if (kind < 2) begin
            // equal counts per color, interleaved
            colors = $urandom_range(2, 3);
            reps   = $urandom_range(1, 6);
            for (int j = 0; j < reps; j++)
               for (int c = 0; c < colors; c++)
                  add_pixel(palette[c].red, palette[c].green, palette[c].blue,
                            (j == reps - 1) && (c == colors - 1));
         end else begin
            len = (kind == 9) ? $urandom_range(100, 200) : $urandom_range(1, 30);
            for (int i = 0; i < len; i++) begin
               p = ($urandom_range(0, 9) < 7) ? palette[$urandom_range(0, 3)]
                                               : random_pixel();
               add_pixel(p.red, p.green, p.blue, i == len - 1);
            end
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // sample settled values away from the active edge
      @(negedge clock);
      while (pixel_queue.size() != 0 || req_valid)
         @(negedge clock);
      while (dominant_queue.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("sent %0d pixels in %0d images, checked %0d dominant-color results",
               pixels_sent, images_queued, results_seen);
      $display("included corner bins, ties, nibble aliasing and a %0d-cycle output hold",
               HOLD_CYCLES);
      if (errors == 0 && dominant_queue.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("%0d errors", errors);
         $display("simulation failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
